/* sv/pgwd_pkg.sv */
// ----------------------------------------------------------------------------
// Packed genotype weighted dot product: shared definitions
// Widths, genotype codes and control types used by the lanes, the merge stage
// and the top level.
// ----------------------------------------------------------------------------
package pgwd_pkg;

  localparam int LANES   = 4;
  localparam int GENO_W  = 8;
  localparam int VEC_W   = 32;
  localparam int WGT_W   = 24;
  localparam int FREQ_W  = 17;
  localparam int CNT_W   = 3;
  localparam int COEF_W  = WGT_W + 1;
  localparam int PROD_W  = VEC_W + COEF_W + 1;
  localparam int LSUM_W  = PROD_W + 2;
  localparam int ACC_W   = 64;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef enum logic [1:0] {
    GENO_ZERO    = 2'd0,
    GENO_ONE     = 2'd1,
    GENO_TWO     = 2'd2,
    GENO_MISSING = 2'd3
  } geno_code_t;

  typedef logic signed [PROD_W-1:0] lane_prod_t;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctrl_t;

endpackage

/* sv/pgwd_lane.sv */
// ----------------------------------------------------------------------------
// Packed genotype weighted dot product: lane
// Maps one genotype code to its coefficient and registers the product with
// the matching vector entry. A lane beyond the valid count yields zero.
// ----------------------------------------------------------------------------
module pgwd_lane (
  input  logic                                clk,
  input  logic                                load,
  input  logic                                lane_on,
  input  pgwd_pkg::geno_code_t                code,
  input  logic signed [pgwd_pkg::VEC_W-1:0]   vec,
  input  logic [pgwd_pkg::WGT_W-1:0]          weight,
  input  logic [pgwd_pkg::FREQ_W-1:0]         freq,
  output pgwd_pkg::lane_prod_t                prod_r
);
  import pgwd_pkg::*;

  logic [COEF_W-1:0]   coef;
  logic signed [COEF_W:0] coef_s;
  lane_prod_t          prod_nxt;

  always_comb begin
    unique case (code)
      GENO_ZERO:    coef = '0;
      GENO_ONE:     coef = COEF_W'(weight);
      GENO_TWO:     coef = {weight, 1'b0};
      GENO_MISSING: coef = COEF_W'({freq, 1'b0});
      default:      coef = '0;
    endcase
    coef_s   = lane_on ? $signed({1'b0, coef}) : '0;
    prod_nxt = PROD_W'(vec) * PROD_W'(coef_s);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

/* sv/pgwd_merge.sv */
// ----------------------------------------------------------------------------
// Packed genotype weighted dot product: merge and accumulate
// Adds the four lane products, then adds that sum into the saturating
// accumulator and emits the result on the last transaction of a row.
// ----------------------------------------------------------------------------
module pgwd_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  pgwd_pkg::stage_ctrl_t              s1_ctrl,
  input  pgwd_pkg::lane_prod_t               lane_prod [pgwd_pkg::LANES],
  output logic                               s2_load,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [pgwd_pkg::ACC_W-1:0]  out_weighted_sum,
  output logic                               out_saturated
);
  import pgwd_pkg::*;

  logic                     s2_v_r;
  logic                     s2_last_r;
  logic signed [LSUM_W-1:0] s2_sum_r;
  logic signed [LSUM_W-1:0] lane_sum;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     clip_r;
  logic signed [ACC_W:0]    acc_wide;
  logic signed [ACC_W-1:0]  acc_sat;
  logic                     add_clip;
  logic                     out_valid_r;
  logic signed [ACC_W-1:0]  out_sum_r;
  logic                     out_sat_r;
  logic                     out_free;
  logic                     acc_fire;

  always_comb begin
    lane_sum = '0;
    for (int k = 0; k < LANES; k++) begin
      lane_sum = lane_sum + LSUM_W'(lane_prod[k]);
    end
  end

  always_comb begin
    acc_wide = $signed({acc_r[ACC_W-1], acc_r}) + (ACC_W+1)'(s2_sum_r);
    add_clip = acc_wide[ACC_W] != acc_wide[ACC_W-1];
    if (add_clip) begin
      acc_sat = acc_wide[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      acc_sat = acc_wide[ACC_W-1:0];
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign acc_fire = s2_v_r && (!s2_last_r || out_free);
  assign s2_load  = !s2_v_r || acc_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      acc_r       <= '0;
      clip_r      <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (acc_fire) begin
        if (s2_last_r) begin
          out_valid_r <= 1'b1;
          out_sum_r   <= acc_sat;
          out_sat_r   <= clip_r || add_clip;
          acc_r       <= '0;
          clip_r      <= 1'b0;
        end else begin
          acc_r  <= acc_sat;
          clip_r <= clip_r || add_clip;
        end
      end
      if (s2_load) begin
        s2_v_r <= s1_ctrl.valid;
        if (s1_ctrl.valid) begin
          s2_sum_r  <= lane_sum;
          s2_last_r <= s1_ctrl.last;
        end
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_weighted_sum = out_sum_r;
  assign out_saturated    = out_sat_r;

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    acc_fire && s2_last_r |=> acc_r == '0 && !clip_r)
    else $error("accumulator not cleared after emission");

  a_last_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s2_v_r && s2_last_r && !out_free |=> s2_v_r && s2_last_r && $stable(s2_sum_r))
    else $error("blocked final lane sum was lost");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s2_v_r && s2_last_r))
    else $error("result raised without a final transaction");

endmodule

/* sv/packed_genotype_weighted_dot.sv */
// ----------------------------------------------------------------------------
// Packed genotype weighted dot product
// Four lanes weight one packed genotype byte against four vector entries; a
// merge stage sums the lanes into a saturating Q32.32 accumulator per row.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Contents
//  in_      input      in_valid/in_stall    genotype byte, 4 entries, row data
//  out_     output     out_valid/out_stall  weighted sum, saturation flag
//
//  One transaction per cycle sustained unless a stalled result holds back the
//  final transaction of a row. Results are registered in the lane multipliers,
//  the lane adder and the accumulator, whose add and saturate loop sets the rate.
//  Reset is synchronous and clears the accumulator and all valid flags.
//  A stalled result holds; transactions flow on until the next end of a row.
// ----------------------------------------------------------------------------
module packed_genotype_weighted_dot (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [pgwd_pkg::GENO_W-1:0]         in_geno_byte,
  input  logic signed [pgwd_pkg::VEC_W-1:0]   in_vec_lane0,
  input  logic signed [pgwd_pkg::VEC_W-1:0]   in_vec_lane1,
  input  logic signed [pgwd_pkg::VEC_W-1:0]   in_vec_lane2,
  input  logic signed [pgwd_pkg::VEC_W-1:0]   in_vec_lane3,
  input  logic [pgwd_pkg::WGT_W-1:0]          in_row_weight,
  input  logic [pgwd_pkg::FREQ_W-1:0]         in_allele_freq,
  input  logic [pgwd_pkg::CNT_W-1:0]          in_valid_count,
  input  logic                                in_last_of_row,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [pgwd_pkg::ACC_W-1:0]   out_weighted_sum,
  output logic                                out_saturated
);
  import pgwd_pkg::*;

  stage_ctrl_t              s1_ctrl_r;
  logic                     s1_load;
  logic                     s2_load;
  logic signed [VEC_W-1:0]  vec [LANES];
  lane_prod_t               lane_prod [LANES];

  assign vec[0] = in_vec_lane0;
  assign vec[1] = in_vec_lane1;
  assign vec[2] = in_vec_lane2;
  assign vec[3] = in_vec_lane3;

  assign in_stall = s1_ctrl_r.valid && !s2_load;
  assign s1_load  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctrl_r <= '0;
    end else if (s1_load) begin
      s1_ctrl_r.valid <= 1'b1;
      s1_ctrl_r.last  <= in_last_of_row;
    end else if (s2_load) begin
      s1_ctrl_r.valid <= 1'b0;
    end
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    pgwd_lane u_lane (
      .clk     (clk),
      .load    (s1_load),
      .lane_on (in_valid_count > CNT_W'(k)),
      .code    (geno_code_t'(in_geno_byte[2*k +: 2])),
      .vec     (vec[k]),
      .weight  (in_row_weight),
      .freq    (in_allele_freq),
      .prod_r  (lane_prod[k])
    );
  end

  pgwd_merge u_merge (
    .clk              (clk),
    .rst_n            (rst_n),
    .s1_ctrl          (s1_ctrl_r),
    .lane_prod        (lane_prod),
    .s2_load          (s2_load),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_weighted_sum (out_weighted_sum),
    .out_saturated    (out_saturated)
  );

endmodule
